// File: hdl/dhhp_pkg.sv
// Package for the diff hunk header parser.
// Holds the request and response payload types, character codes and sizes.
// No dependencies.
package dhhp_pkg;

   localparam int NUMBER_WIDTH_DEF = 24;
   localparam int FIELD_WIDTH      = 24;

   localparam logic [7:0] CH_GT    = 8'h3e;  // '>'
   localparam logic [7:0] CH_LT    = 8'h3c;  // '<'
   localparam logic [7:0] CH_DASH  = 8'h2d;  // '-'
   localparam logic [7:0] CH_DOT   = 8'h2e;  // '.'
   localparam logic [7:0] CH_COMMA = 8'h2c;  // ','
   localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
   localparam logic [7:0] CH_NINE  = 8'h39;  // '9'

   typedef struct packed {
      logic [7:0] character;
      logic       line_end;
   } req_type;

   typedef struct packed {
      logic                   is_command;
      logic [7:0]             command_char;
      logic [FIELD_WIDTH-1:0] left_from;
      logic [FIELD_WIDTH-1:0] left_to;
      logic [FIELD_WIDTH-1:0] right_from;
      logic [FIELD_WIDTH-1:0] right_to;
   } rsp_type;

endpackage

// File: hdl/dhhp_dec_acc.sv
// Decimal digit accumulate: acc * 10 + digit, saturating at all ones.
// Depends on nothing beyond its parameter.
module dhhp_dec_acc #(
   parameter int NW = 24
) (
   input  logic [NW-1:0] acc,
   input  logic [3:0]    digit,
   output logic [NW-1:0] acc_next
);
   logic [NW+3:0] wide;
   logic [NW+3:0] prod;
   logic [NW+3:0] limit;

   assign wide     = {4'b0, acc};
   assign prod     = (wide << 3) + (wide << 1) + {{NW{1'b0}}, digit};
   assign limit    = {4'b0, {NW{1'b1}}};
   assign acc_next = (prod > limit) ? {NW{1'b1}} : prod[NW-1:0];
endmodule

// File: hdl/dhhp_parse.sv
// Per-line parse state and next-state logic for the hunk header parser.
// Depends on dhhp_pkg and dhhp_dec_acc.
module dhhp_parse #(
   parameter int NUMBER_WIDTH = dhhp_pkg::NUMBER_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              go,
   input  dhhp_pkg::req_type item,
   output dhhp_pkg::rsp_type result
);
   import dhhp_pkg::*;

   localparam int NW = NUMBER_WIDTH;

   localparam logic [2:0] PH_START   = 3'd0;
   localparam logic [2:0] PH_LFROM   = 3'd1;
   localparam logic [2:0] PH_LTO     = 3'd2;
   localparam logic [2:0] PH_RFROM   = 3'd3;
   localparam logic [2:0] PH_RTO     = 3'd4;
   localparam logic [2:0] PH_SKIP    = 3'd5;
   localparam logic [2:0] PH_CONTENT = 3'd6;

   logic [2:0]    phase_ff, phase_in, phase0;
   logic [NW-1:0] lf_ff, lf_in, lt_ff, lt_in, rf_ff, rf_in, rt_ff, rt_in;
   logic          lt_seen_ff, lt_seen_in, rt_seen_ff, rt_seen_in;
   logic [7:0]    held_ff, held_in;

   logic [7:0]    ch;
   logic          is_digit, is_content, cmd;
   logic [3:0]    dval;
   logic [NW-1:0] acc_sel, acc_new;
   logic [NW+FIELD_WIDTH-1:0] lf_x, lt_x, rf_x, rt_x;

   assign ch         = item.character;
   assign is_digit   = (ch >= CH_ZERO) && (ch <= CH_NINE);
   assign is_content = (ch == CH_GT) || (ch == CH_LT) || (ch == CH_DASH) || (ch == CH_DOT);
   // digit codes sit at 0x30..0x39, so the low nibble is the value
   assign dval       = ch[3:0];

   always_comb begin
      if (phase_ff == PH_START) begin
         phase0 = is_content ? PH_CONTENT : PH_LFROM;
      end else begin
         phase0 = phase_ff;
      end
   end

   always_comb begin
      case (phase0)
         PH_LTO:   acc_sel = lt_ff;
         PH_RFROM: acc_sel = rf_ff;
         PH_RTO:   acc_sel = rt_ff;
         default:  acc_sel = lf_ff;
      endcase
   end

   dhhp_dec_acc #(.NW(NW)) u_acc (
      .acc      (acc_sel),
      .digit    (dval),
      .acc_next (acc_new)
   );

   always_comb begin
      phase_in   = phase0;
      lf_in      = lf_ff;
      lt_in      = lt_ff;
      rf_in      = rf_ff;
      rt_in      = rt_ff;
      lt_seen_in = lt_seen_ff;
      rt_seen_in = rt_seen_ff;
      held_in    = held_ff;
      case (phase0)
         PH_LFROM: begin
            if (is_digit) begin
               lf_in = acc_new;
            end else if (ch == CH_COMMA) begin
               lt_seen_in = 1'b1;
               phase_in   = PH_LTO;
            end else begin
               held_in  = ch;
               phase_in = PH_RFROM;
            end
         end
         PH_LTO: begin
            if (is_digit) begin
               lt_in = acc_new;
            end else begin
               held_in  = ch;
               phase_in = PH_RFROM;
            end
         end
         PH_RFROM: begin
            if (is_digit) begin
               rf_in = acc_new;
            end else if (ch == CH_COMMA) begin
               rt_seen_in = 1'b1;
               phase_in   = PH_RTO;
            end else begin
               phase_in = PH_SKIP;
            end
         end
         PH_RTO: begin
            if (is_digit) begin
               rt_in = acc_new;
            end else begin
               phase_in = PH_SKIP;
            end
         end
         default: begin
            phase_in = phase0;
         end
      endcase
   end

   // command byte taken once the parse has moved into the right-hand side
   assign cmd = ((phase_in == PH_RFROM) || (phase_in == PH_RTO) || (phase_in == PH_SKIP))
                && (held_in != 8'd0);

   assign lf_x = {{FIELD_WIDTH{1'b0}}, lf_in};
   assign lt_x = {{FIELD_WIDTH{1'b0}}, (lt_seen_in ? lt_in : lf_in)};
   assign rf_x = {{FIELD_WIDTH{1'b0}}, rf_in};
   assign rt_x = {{FIELD_WIDTH{1'b0}}, (rt_seen_in ? rt_in : rf_in)};

   always_comb begin
      result.is_command   = cmd;
      result.command_char = cmd ? held_in : 8'd0;
      result.left_from    = cmd ? lf_x[FIELD_WIDTH-1:0] : '0;
      result.left_to      = cmd ? lt_x[FIELD_WIDTH-1:0] : '0;
      result.right_from   = cmd ? rf_x[FIELD_WIDTH-1:0] : '0;
      result.right_to     = cmd ? rt_x[FIELD_WIDTH-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset || (go && item.line_end)) begin
         phase_ff   <= PH_START;
         lf_ff      <= '0;
         lt_ff      <= '0;
         rf_ff      <= '0;
         rt_ff      <= '0;
         lt_seen_ff <= 1'b0;
         rt_seen_ff <= 1'b0;
         held_ff    <= 8'd0;
      end else if (go) begin
         phase_ff   <= phase_in;
         lf_ff      <= lf_in;
         lt_ff      <= lt_in;
         rf_ff      <= rf_in;
         rt_ff      <= rt_in;
         lt_seen_ff <= lt_seen_in;
         rt_seen_ff <= rt_seen_in;
         held_ff    <= held_in;
      end
   end
endmodule

// File: hdl/diff_hunk_header_parser.sv
// Diff hunk header parser, top level: input register, parser, response register.
// Depends on dhhp_pkg, dhhp_parse and dhhp_dec_acc.
//
// Usage:
//   The req channel carries one character of a diff output line per request,
//   newline included, with line_end set on the final character. The rsp
//   channel returns one response per line: the decoded A[,B]xC[,D] header,
//   or is_command = 0 for a content line.
//   Both channels use valid/stall; a request moves when valid is high and
//   stall is low.
//   Throughput: one character per cycle, sustained, while rsp is not stalled.
//   Response path: the response for a line becomes valid after the request
//   carrying line_end has passed the input register, then the response register.
//   Stall: while a response waits under rsp_stall, non-final characters keep
//   flowing; a final character waits in the input register, and req_stall
//   rises only once that register holds it.
//   Reset: synchronous; returns the parser to line start with all numbers
//   zero and empties both registers.
module diff_hunk_header_parser #(
   parameter int NUMBER_WIDTH = dhhp_pkg::NUMBER_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dhhp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dhhp_pkg::rsp_type rsp_data
);
   import dhhp_pkg::*;

   logic    s1_valid_ff, s1_valid_in;
   req_type s1_data_ff;
   logic    s1_go, accept;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;
   rsp_type line_result;

   assign s1_go     = s1_valid_ff && (!s1_data_ff.line_end || !rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_go;
   assign accept    = req_valid && !req_stall;

   assign s1_valid_in  = accept || (s1_valid_ff && !s1_go);
   assign rsp_valid_in = (s1_go && s1_data_ff.line_end) || (rsp_valid_ff && rsp_stall);

   dhhp_parse #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_parse (
      .clock  (clock),
      .reset  (reset),
      .go     (s1_go),
      .item   (s1_data_ff),
      .result (line_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_data_ff <= req_data;
      end
      if (s1_go && s1_data_ff.line_end) begin
         rsp_data_ff <= line_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
endmodule
